// ----- rtl/srr_pkg.sv -----
package srr_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 15;
    localparam int MIN_LEN_W   = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SILENCE_LEVEL  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RUN_LENGTH = 2'd1;

    localparam logic [LEVEL_W-1:0]   LEVEL_RESET   = 15'd256;
    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 7'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SEND,
        ST_LOUD,
        ST_MARK
    } state_t;

    typedef enum logic [1:0] {
        SEL_RUN,
        SEL_LOUD,
        SEL_MARK
    } out_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     rd_en;
        logic     out_load;
        out_sel_t sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic more;
        logic loud;
        logic final_item;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/srr_if.sv -----
interface srr_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [srr_pkg::SAMPLE_W-1:0] sample_in;
    logic                                final_sample;

    modport source (output valid, output sample_in, output final_sample, input ready);
    modport sink (input valid, input sample_in, input final_sample, output ready);
endinterface

interface srr_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [srr_pkg::SAMPLE_W-1:0] sample_out;
    logic                                sample_valid;
    logic                                burst_last;
    logic                                stream_end;

    modport source (output valid, output sample_out, output sample_valid,
                    output burst_last, output stream_end, input ready);
    modport sink (input valid, input sample_out, input sample_valid,
                  input burst_last, input stream_end, output ready);
endinterface

interface srr_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [srr_pkg::CFG_INDEX_W-1:0]        index;
    logic [srr_pkg::CFG_DATA_W-1:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/srr_ctrl.sv -----
module srr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  srr_pkg::dp_status_t status,
    output srr_pkg::ctrl_cmd_t  cmd
);
    import srr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                priority if (status.more)
                    state_next = ST_SEND;
                else if (status.loud)
                    state_next = ST_LOUD;
                else if (status.final_item)
                    state_next = ST_MARK;
                else
                    state_next = ST_IDLE;
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    priority if (status.more)
                        state_next = ST_SEND;
                    else if (status.loud)
                        state_next = ST_LOUD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_LOUD, ST_MARK:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load_item = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.sel       = SEL_RUN;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_START:
            begin
                // first read of a pending run goes out here
                cmd.rd_en = status.more;
            end
            ST_SEND:
            begin
                cmd.out_load = status.out_free;
                cmd.rd_en    = status.out_free && status.more;
                cmd.sel      = SEL_RUN;
            end
            ST_LOUD:
            begin
                cmd.out_load = status.out_free;
                cmd.sel      = SEL_LOUD;
            end
            ST_MARK:
            begin
                cmd.out_load = status.out_free;
                cmd.sel      = SEL_MARK;
            end
        endcase
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("input taken outside idle");

    a_load_goes_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> (state_reg == ST_START))
        else $error("accepted item not started");

    a_read_needs_more: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> status.more)
        else $error("read issued with no pending entry");

endmodule

// ----- rtl/srr_datapath.sv -----
module srr_datapath #(
    parameter int MAX_RUN_LENGTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srr_pkg::ctrl_cmd_t                  cmd,
    output srr_pkg::dp_status_t                 status,
    input  logic signed [srr_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                final_sample,
    input  logic                                cfg_valid,
    input  logic [srr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [srr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [srr_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                sample_valid,
    output logic                                burst_last,
    output logic                                stream_end
);
    import srr_pkg::*;

    localparam int DEPTH = MAX_RUN_LENGTH - 1;
    localparam int AW    = (MAX_RUN_LENGTH > 2) ? $clog2(MAX_RUN_LENGTH - 1) : 1;
    localparam int CW    = $clog2(MAX_RUN_LENGTH);
    localparam int NW    = $clog2(MAX_RUN_LENGTH + 1);

    logic [LEVEL_W-1:0]   level_reg;
    logic [MIN_LEN_W-1:0] min_reg;

    logic [SAMPLE_W-1:0] store_mem [0:DEPTH-1];
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic [NW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] len_reg, len_next;
    logic          loud_reg, final_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg, out_data_next;
    logic                out_sv_reg, out_sv_next;
    logic                out_last_reg, out_last_next;
    logic                out_end_reg, out_end_next;

    logic [NW-1:0]       eff_min;
    logic signed [16:0]  samp_ext;
    logic signed [16:0]  lvl_ext;
    logic                silent;
    logic                below_min;
    logic [NW-1:0]       count_after;
    logic                wr_en;
    logic                more;
    logic                out_free;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LEVEL_RESET;
            min_reg   <= MIN_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_SILENCE_LEVEL)
            begin
                level_reg <= cfg_data[LEVEL_W-1:0];
            end
            else if (cfg_index == CFG_MIN_RUN_LENGTH)
            begin
                min_reg <= cfg_data[MIN_LEN_W-1:0];
            end
        end
    end

    // minimum clamped into one to MAX_RUN_LENGTH
    always_comb
    begin
        priority if (min_reg == '0)
            eff_min = NW'(1);
        else if (min_reg > MIN_LEN_W'(MAX_RUN_LENGTH))
            eff_min = NW'(MAX_RUN_LENGTH);
        else
            eff_min = min_reg[NW-1:0];
    end

    always_comb
    begin
        samp_ext  = {sample_in[SAMPLE_W-1], sample_in};
        lvl_ext   = $signed({2'b00, level_reg});
        silent    = (samp_ext <= lvl_ext) && (samp_ext >= -lvl_ext);
        below_min = count_reg < eff_min;
        count_after = (silent && below_min) ? count_reg + NW'(1) : count_reg;
        wr_en     = cmd.load_item && silent && below_min && (count_reg < NW'(DEPTH));
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        if (cmd.load_item)
        begin
            count_next = (!silent || final_sample) ? '0 : count_after;
            idx_next   = '0;
            if (silent)
            begin
                len_next = (final_sample && (count_after < eff_min)) ?
                           count_after[CW-1:0] : '0;
            end
            else
            begin
                len_next = below_min ? count_reg[CW-1:0] : '0;
            end
        end
        else if (cmd.rd_en)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            len_reg   <= '0;
            loud_reg  <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            if (cmd.load_item)
            begin
                loud_reg  <= !silent;
                final_reg <= final_sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            sample_reg <= sample_in;
        end
    end

    // run buffer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[count_reg[AW-1:0]] <= sample_in;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[idx_reg[AW-1:0]];
        end
    end

    assign more     = idx_reg != len_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_data_next = out_data_reg;
        out_sv_next   = out_sv_reg;
        out_last_next = out_last_reg;
        out_end_next  = out_end_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            unique case (cmd.sel)
                SEL_RUN:
                begin
                    out_data_next = rd_data_reg;
                    out_sv_next   = 1'b1;
                    out_last_next = !more && !loud_reg;
                    out_end_next  = !more && !loud_reg && final_reg;
                end
                SEL_LOUD:
                begin
                    out_data_next = sample_reg;
                    out_sv_next   = 1'b1;
                    out_last_next = 1'b1;
                    out_end_next  = final_reg;
                end
                SEL_MARK:
                begin
                    out_data_next = '0;
                    out_sv_next   = 1'b0;
                    out_last_next = 1'b1;
                    out_end_next  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_sv_reg   <= out_sv_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

    assign status.more       = more;
    assign status.loud       = loud_reg;
    assign status.final_item = final_reg;
    assign status.out_free   = out_free;

    assign out_valid    = out_valid_reg;
    assign sample_out   = $signed(out_data_reg);
    assign sample_valid = out_sv_reg;
    assign burst_last   = out_last_reg;
    assign stream_end   = out_end_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(MAX_RUN_LENGTH))
        else $error("run counter beyond maximum");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_item && final_sample) |=> (count_reg == '0))
        else $error("run counter not cleared at stream end");

endmodule

// ----- rtl/silence_run_remover.sv -----
// silence_run_remover
// drops silent runs of at least min_run_length samples from a 16-bit audio stream.
// samples: valid/ready input channel, one sample and its final_sample flag per transaction.
// results: valid/ready output channel, one kept sample (or an end marker) per transaction,
//   burst_last closes the results of one input, stream_end the whole stream.
// cfg: write channel, index 0 silence_level, index 1 min_run_length; always ready,
//   write only while the block is idle.
// one input is taken at a time. an input with no result passes through IDLE and START,
//   a loud sample or end marker also through LOUD or MARK, and a flushed run holds SEND
//   until its last sample; the flush streams one buffered sample per cycle, while the
//   receiver is ready, from the run buffer memory, which has a registered read port.
//   the first result enters the output register from SEND, LOUD or MARK, after START.
// a finished result sits in an output register; the next input is taken while it
//   waits. when the receiver stalls the flush holds in place and resumes with no loss.
// reset (rst_n low, asynchronous) restores the register defaults and empties the run;
//   the buffer itself needs no clearing.
module silence_run_remover #(
    parameter int MAX_RUN_LENGTH = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    srr_sample_if.sink   samples,
    srr_result_if.source results,
    srr_cfg_if.sink      cfg
);
    import srr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    srr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    srr_datapath #(
        .MAX_RUN_LENGTH (MAX_RUN_LENGTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_in    (samples.sample_in),
        .final_sample (samples.final_sample),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .out_ready    (results.ready),
        .out_valid    (results.valid),
        .sample_out   (results.sample_out),
        .sample_valid (results.sample_valid),
        .burst_last   (results.burst_last),
        .stream_end   (results.stream_end)
    );

endmodule

// ----- sim/silence_run_remover_test.sv -----
`timescale 1ns / 100ps

module silence_run_remover_test;
    import srr_pkg::*;

    localparam int MAX_RUN = 64;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_of_stream;
    } audio_item_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       sample_valid;
        logic                       burst_last;
        logic                       stream_end;
    } kept_sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    srr_sample_if samples_if ();
    srr_result_if results_if ();
    srr_cfg_if    cfg_if ();

    silence_run_remover #(
        .MAX_RUN_LENGTH(MAX_RUN)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    // shadow of the block's registers and run buffer
    logic [LEVEL_W-1:0]         level_shadow = LEVEL_RESET;
    logic [MIN_LEN_W-1:0]       min_len_shadow = MIN_LEN_RESET;
    logic signed [SAMPLE_W-1:0] quiet_run [MAX_RUN-1];
    int unsigned                quiet_count = 0;

    audio_item_t  sample_queue [$];
    kept_sample_t kept_expected [$];
    audio_item_t  item_on_bus;
    int unsigned  items_queued = 0;
    int unsigned  items_taken = 0;
    int unsigned  mismatch_count = 0;
    bit           steady = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic kept_sample_t make_kept(logic signed [SAMPLE_W-1:0] s, logic v);
        kept_sample_t k;
        k.sample_out   = s;
        k.sample_valid = v;
        k.burst_last   = 1'b0;
        k.stream_end   = 1'b0;
        return k;
    endfunction

    function automatic void predict_kept_samples(audio_item_t it);
        kept_sample_t burst [$];
        int unsigned  eff_min;
        int           s;
        int           lvl;
        bit           drop_run;
        eff_min = min_len_shadow;
        if (eff_min < 1)
            eff_min = 1;
        if (eff_min > MAX_RUN)
            eff_min = MAX_RUN;
        s = it.sample;
        lvl = level_shadow;
        drop_run = quiet_count >= eff_min;
        if (s >= -lvl && s <= lvl)
        begin
            if (quiet_count < eff_min)
            begin
                if (quiet_count < MAX_RUN - 1)
                    quiet_run[quiet_count] = it.sample;
                quiet_count++;
            end
            drop_run = quiet_count >= eff_min;
            if (it.last_of_stream && !drop_run)
                for (int i = 0; i < quiet_count && i < MAX_RUN - 1; i++)
                    burst.insert(burst.size(), make_kept(quiet_run[i], 1'b1));
        end
        else
        begin
            if (!drop_run)
                for (int i = 0; i < quiet_count && i < MAX_RUN - 1; i++)
                    burst.insert(burst.size(), make_kept(quiet_run[i], 1'b1));
            quiet_count = 0;
            burst.insert(burst.size(), make_kept(it.sample, 1'b1));
        end
        if (it.last_of_stream)
        begin
            quiet_count = 0;
            // end marker when the final transaction keeps nothing
            if (burst.size() == 0)
                burst.insert(0, make_kept('0, 1'b0));
            burst[burst.size()-1].stream_end = 1'b1;
        end
        if (burst.size() != 0)
            burst[burst.size()-1].burst_last = 1'b1;
        foreach (burst[i])
            kept_expected.insert(kept_expected.size(), burst[i]);
    endfunction

    // sample driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (samples_if.valid && samples_if.ready)
            begin
                predict_kept_samples(item_on_bus);
                items_taken++;
            end
            if (!samples_if.valid || samples_if.ready)
            begin
                if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= 7))
                begin
                    item_on_bus = sample_queue.pop_front();
                    samples_if.valid        <= 1'b1;
                    samples_if.sample_in    <= item_on_bus.sample;
                    samples_if.final_sample <= item_on_bus.last_of_stream;
                end
                else
                    samples_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        kept_sample_t want;
        if (rst_n)
        begin
            if (results_if.valid && results_if.ready)
            begin
                if (kept_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: sample_out %0d valid %b last %b end %b",
                                 results_if.sample_out, results_if.sample_valid,
                                 results_if.burst_last, results_if.stream_end);
                end
                else
                begin
                    want = kept_expected.pop_front();
                    if (results_if.sample_out !== want.sample_out
                        || results_if.sample_valid !== want.sample_valid
                        || results_if.burst_last !== want.burst_last
                        || results_if.stream_end !== want.stream_end)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %0d/%b/%b/%b got %0d/%b/%b/%b",
                                     want.sample_out, want.sample_valid, want.burst_last,
                                     want.stream_end, results_if.sample_out,
                                     results_if.sample_valid, results_if.burst_last,
                                     results_if.stream_end);
                    end
                end
            end
            results_if.ready <= steady || $urandom_range(99) >= 7;
        end
    end

    task automatic add_item(input logic signed [SAMPLE_W-1:0] s, input logic fin);
        audio_item_t it;
        it.sample = s;
        it.last_of_stream = fin;
        sample_queue.insert(sample_queue.size(), it);
        items_queued++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] quiet_sample(input int lvl);
        int m;
        m = ($urandom_range(7) == 0) ? lvl : $urandom_range(lvl);
        return SAMPLE_W'($urandom_range(1) ? -m : m);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] loud_sample(input int lvl);
        int m;
        if (lvl == 32767)
            return SAMPLE_W'(-32768);
        m = ($urandom_range(7) == 0) ? lvl + 1 : $urandom_range(32768, lvl + 1);
        if (m == 32768)
            return SAMPLE_W'(-32768);
        return SAMPLE_W'($urandom_range(1) ? -m : m);
    endfunction

    // only while nothing is in flight
    task automatic write_config(input int lvl, input int mlen);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_SILENCE_LEVEL;
        cfg_if.data  <= CFG_DATA_W'(lvl);
        do @(posedge clk); while (!cfg_if.ready);
        level_shadow = LEVEL_W'(lvl);
        cfg_if.index <= CFG_MIN_RUN_LENGTH;
        cfg_if.data  <= CFG_DATA_W'(mlen);
        do @(posedge clk); while (!cfg_if.ready);
        min_len_shadow = MIN_LEN_W'(mlen);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || kept_expected.size() != 0)
            @(posedge clk);
        // non-final quiet samples keep the block busy briefly with nothing to show
        repeat (8) @(posedge clk);
    endtask

    // mostly quiet runs around the minimum length closed by a loud sample or end of stream
    task automatic fill_random_phase(input int lvl, input int mlen, input int target);
        int n;
        int len;
        int pick;
        n = 0;
        while (n < target)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_item(SAMPLE_W'($urandom_range(16'hffff)), $urandom_range(15) == 0);
                n++;
            end
            else
            begin
                case ($urandom_range(3))
                    0: len = $urandom_range(mlen - 1);
                    1: len = mlen - 1;
                    2: len = mlen;
                    default: len = mlen + $urandom_range(4, 1);
                endcase
                repeat (len) add_item(quiet_sample(lvl), 1'b0);
                pick = $urandom_range(9);
                if (pick < 8)
                    add_item(loud_sample(lvl), 1'b0);
                else if (pick == 8)
                    add_item(loud_sample(lvl), 1'b1);
                else
                    add_item(quiet_sample(lvl), 1'b1);
                n += len + 1;
            end
        end
    endtask

    initial
    begin
        int lvl;
        int mlen;
        samples_if.valid        = 1'b0;
        samples_if.sample_in    = '0;
        samples_if.final_sample = 1'b0;
        results_if.ready        = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.index            = CFG_SILENCE_LEVEL;
        cfg_if.data             = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        add_item(16'sd32767, 1'b0);
        add_item(-16'sd32768, 1'b0);
        add_item(16'sd0, 1'b0);
        add_item(16'sd256, 1'b0);
        add_item(-16'sd256, 1'b0);
        add_item(16'sd257, 1'b0);
        add_item(-16'sd257, 1'b0);
        add_item(16'sd100, 1'b1);
        add_item(16'sd1000, 1'b1);
        wait_drained();

        // level zero, every quiet sample removed, end markers
        write_config(0, 1);
        add_item(16'sd0, 1'b0);
        add_item(16'sd0, 1'b1);
        add_item(16'sd1, 1'b0);
        add_item(-16'sd1, 1'b0);
        add_item(-16'sd32768, 1'b0);
        add_item(16'sd0, 1'b1);
        wait_drained();

        // widest level and longest run, leaving a run open across the next write
        write_config(32767, MAX_RUN);
        add_item(16'sd32767, 1'b0);
        add_item(-16'sd32767, 1'b0);
        add_item(16'sd0, 1'b0);
        add_item(-16'sd32768, 1'b0);
        add_item(16'sd5, 1'b1);
        add_item(-16'sd3, 1'b0);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(7))
                0: lvl = 0;
                1: lvl = 32767;
                2, 3: lvl = $urandom_range(255);
                4, 5: lvl = $urandom_range(4095);
                default: lvl = $urandom_range(32767);
            endcase
            case ($urandom_range(9))
                0: mlen = MAX_RUN;
                1: mlen = 1;
                2: mlen = $urandom_range(MAX_RUN, 1);
                default: mlen = $urandom_range(12, 1);
            endcase
            steady = (p == 3);
            write_config(lvl, mlen);
            fill_random_phase(lvl, mlen, 16);
            wait_drained();
        end

        if (mismatch_count == 0 && kept_expected.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
